// File: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Transfer structs, mode codes and datapath widths used by the top level and
// the iterative divider.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_W          = 16;
    localparam int MIN_POLY         = 3;

    // Mode codes of an input transfer
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Edge arithmetic: 17b signed differences, 34b signed product,
    // 32b product magnitude divided by a 16b divisor magnitude
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DVD_W       = 2 * COORD_W;
    localparam int DVS_W       = COORD_W;
    localparam int DIV_CNT_W   = $clog2(DVD_W);

    typedef struct packed {
        logic [1:0]         mode;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } item_t;

    typedef struct packed {
        logic       inside_res;
        logic       polygon_ready;
        logic       append_refused;
        logic [6:0] stored_count;
    } res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/pip_div.sv
// ----------------------------------------------------------------------------
// pip_div: iterative unsigned restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module pip_div
    import pip_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 ge;
    logic [DVS_W-1:0]     rem_step;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_step = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend shifts out of the top of quo_reg as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: polygon store with ray-casting inside test
// Holds up to MAX_VERTICES vertices and answers point queries by counting
// the edges that a ray to the right of the point crosses.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (item_*) carries mode, coord_x, coord_y. Mode clear empties
//   the store, append adds a vertex (refused when full), query tests a point.
//   Every input transfer yields exactly one result transfer (res_*).
//   Clear, append, unused codes and queries on fewer than three vertices:
//   the result is registered and shows in the cycle after the input transfer.
//   Query: each edge that misses the query row takes a fetch and a straddle
//   test; each edge that straddles it also takes one multiply and a pass
//   through the shared iterative divider.
//   The block takes one item at a time; item_stall is high for the whole of
//   a query and also while a finished result is held by res_stall.
//   The result register holds a waiting result while res_stall is high; a new
//   item is taken in the same cycle as the waiting result transfers.
//   Reset empties the store (count zero) and drops any pending result;
//   vertex memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item_data,
    output logic  res_valid,
    input  logic  res_stall,
    output res_t  res_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int XW = PROD_W - COORD_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] CNT_MIN = CW'(MIN_POLY);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOADJ   = 3'd1;  // latch closing vertex n-1
    localparam logic [2:0] S_FETCH   = 3'd2;  // memory read in flight
    localparam logic [2:0] S_EDGE    = 3'd3;  // straddle test, multiply
    localparam logic [2:0] S_DIVGO   = 3'd4;
    localparam logic [2:0] S_DIVWAIT = 3'd5;
    localparam logic [2:0] S_NEXT    = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    // Control registers
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          inside_reg, inside_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    // Payload registers
    logic [COORD_W-1:0]       px_reg, py_reg;
    logic [COORD_W-1:0]       xj_reg, yj_reg;
    logic [COORD_W-1:0]       xi_reg, yi_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DVS_W-1:0]         dvs_reg;
    logic                     neg_reg;

    // Vertex memory: {x, y} per entry
    logic [2*COORD_W-1:0] vtx_mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;

    logic                     item_acc;
    logic                     out_free;
    logic [CW-1:0]            count_m1;
    logic [AW-1:0]            last_addr;
    logic [COORD_W-1:0]       rd_x, rd_y;
    logic                     straddle;
    logic signed [DIFF_W-1:0] dx, ry, dyv;
    logic signed [PROD_W-1:0] prod_w;
    logic [DVS_W-1:0]         dvs_abs;
    logic [PROD_W-1:0]        prod_abs;
    logic signed [PROD_W-1:0] q_ext, xi_ext, px_ext, cross_x;
    logic                     flip;
    logic                     load_res;
    logic                     refused;

    logic             div_start;
    div_stat_t        div_stat;
    logic [DVD_W-1:0] div_quo;

    pip_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_abs[DVD_W-1:0]),
        .divisor  (dvs_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign item_acc   = item_valid && !item_stall;
    assign out_free   = !res_valid_reg || !res_stall;
    assign item_stall = (state_reg != S_IDLE) || !out_free;
    assign div_start  = (state_reg == S_DIVGO);

    assign count_m1  = count_reg - CW'(1);
    assign last_addr = count_m1[AW-1:0];

    // In idle the read port fetches the closing vertex ahead of a query
    assign rd_addr = (state_reg == S_IDLE) ? last_addr : idx_reg;
    assign mem_we  = item_acc && (item_data.mode == MODE_APPEND) && (count_reg < CNT_MAX);

    assign rd_x = rd_data_reg[2*COORD_W-1:COORD_W];
    assign rd_y = rd_data_reg[COORD_W-1:0];

    // Edge arithmetic: vertex i from the read port, vertex j held
    always_comb
    begin
        straddle = (rd_y > py_reg) != (yj_reg > py_reg);
        dx       = $signed({1'b0, xj_reg}) - $signed({1'b0, rd_x});
        ry       = $signed({1'b0, py_reg}) - $signed({1'b0, rd_y});
        dyv      = $signed({1'b0, yj_reg}) - $signed({1'b0, rd_y});
        prod_w   = PROD_W'(dx) * PROD_W'(ry);
        dvs_abs  = dyv[DIFF_W-1] ? DVS_W'(-dyv) : DVS_W'(dyv);
        prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        q_ext    = $signed({{(PROD_W-DVD_W){1'b0}}, div_quo});
        xi_ext   = $signed({{XW{1'b0}}, xi_reg});
        px_ext   = $signed({{XW{1'b0}}, px_reg});
        cross_x  = neg_reg ? (xi_ext - q_ext) : (xi_ext + q_ext);
        flip     = (px_ext < cross_x);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        inside_next    = inside_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        load_res       = 1'b0;
        refused        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    case (item_data.mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            load_res   = 1'b1;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                refused = 1'b1;
                            end
                            load_res = 1'b1;
                        end
                        MODE_QUERY:
                        begin
                            if (count_reg >= CNT_MIN)
                            begin
                                idx_next    = '0;
                                inside_next = 1'b0;
                                state_next  = S_LOADJ;
                            end
                            else
                            begin
                                load_res = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            S_LOADJ:
            begin
                state_next = S_EDGE;
            end
            S_FETCH:
            begin
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                state_next = straddle ? S_DIVGO : S_NEXT;
            end
            S_DIVGO:
            begin
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (div_stat.done)
                begin
                    inside_next = inside_reg ^ flip;
                    state_next  = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (idx_reg == last_addr)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_next.inside_res     = inside_reg;
                    res_next.polygon_ready  = (count_reg >= CNT_MIN);
                    res_next.append_refused = 1'b0;
                    res_next.stored_count   = 7'(count_reg);
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_res)
        begin
            res_next.inside_res     = 1'b0;
            res_next.polygon_ready  = (count_next >= CNT_MIN);
            res_next.append_refused = refused;
            res_next.stored_count   = 7'(count_next);
            res_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            inside_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            inside_reg    <= inside_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vtx_mem[count_reg[AW-1:0]] <= {item_data.coord_x, item_data.coord_y};
        end
        rd_data_reg <= vtx_mem[rd_addr];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (item_acc)
        begin
            px_reg <= item_data.coord_x;
            py_reg <= item_data.coord_y;
        end
        if (state_reg == S_LOADJ)
        begin
            xj_reg <= rd_x;
            yj_reg <= rd_y;
        end
        else if (state_reg == S_NEXT)
        begin
            xj_reg <= xi_reg;
            yj_reg <= yi_reg;
        end
        if (state_reg == S_EDGE)
        begin
            xi_reg   <= rd_x;
            yi_reg   <= rd_y;
            prod_reg <= prod_w;
            dvs_reg  <= dvs_abs;
            neg_reg  <= prod_w[PROD_W-1] ^ dyv[DIFF_W-1];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Assertions
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("vertex count above store depth");

    a_query_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg >= CNT_MIN))
        else $error("edge walk running on fewer than three vertices");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) && $past(state_reg != S_IDLE) |-> $stable(count_reg))
        else $error("vertex count changed during a query");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (idx_reg <= last_addr))
        else $error("edge index beyond last vertex");

endmodule
